>>> sv/vch_pkg.sv
package vch_pkg;

  localparam int MAX_VAPORS_DEF = 1024;
  localparam int ATOM_TYPES_DEF = 16;
  localparam int COORD_W        = 32;
  localparam int DIFF_W         = 33;
  localparam int SQ_W           = 68;
  localparam int DIST_W         = 34;
  localparam int GAP_W          = 35;
  localparam int MOL_W          = 10;
  localparam int TYPE_W         = 4;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE  = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PAIR = 1'b1;

  localparam logic EV_LEAVE  = 1'b0;
  localparam logic EV_ARRIVE = 1'b1;

  // Start value of the running minimum, 2^33-1
  localparam logic signed [GAP_W-1:0] MIN_START = GAP_W'(64'sd8589934591);

  // Sample handed from the distance front end to the decision back end
  typedef struct packed {
    logic                    last;
    logic [MOL_W-1:0]        mol;
    logic signed [GAP_W-1:0] gap;
  } gap_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [GAP_W-1:0] v);
    logic signed [31:0] r;
    if (v > GAP_W'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -GAP_W'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> sv/vch_ram.sv
module vch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> sv/vch_front.sv
// Distance front end: absolute differences, squares, sum, bit-serial isqrt,
// table subtract. One item at a time.
module vch_front
  import vch_pkg::*;
#(
  parameter int MAX_VAPORS = MAX_VAPORS_DEF,
  parameter int ATOM_TYPES = ATOM_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [MOL_W-1:0]   vapor_index,
  input  logic [TYPE_W-1:0]  vapor_atom_type,
  input  logic [TYPE_W-1:0]  ion_atom_type,
  input  logic signed [31:0] vapor_x,
  input  logic signed [31:0] vapor_y,
  input  logic signed [31:0] vapor_z,
  input  logic signed [31:0] ion_x,
  input  logic signed [31:0] ion_y,
  input  logic signed [31:0] ion_z,
  input  logic               last_pair,
  input  logic [31:0]        table_value,
  output logic               q_push,
  output gap_item_t          q_data,
  input  logic               q_full
);
  localparam int TAB_D  = ATOM_TYPES * ATOM_TYPES;
  localparam int TAB_AW = (TAB_D > 1) ? $clog2(TAB_D) : 1;
  localparam int TYP_AW = (ATOM_TYPES > 1) ? $clog2(ATOM_TYPES) : 1;
  localparam int VMW    = (MAX_VAPORS > 1) ? $clog2(MAX_VAPORS) : 1;
  localparam int BIT_W  = 6;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_SUM  = 5'b00100,
    S_ROOT = 5'b01000,
    S_OUT  = 5'b10000
  } fst_t;

  fst_t state_r, state_nxt;
  logic [DIFF_W-1:0]  dx_r, dy_r, dz_r;
  logic [65:0]        sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0]    rem_r;
  logic [DIST_W-1:0]  root_r;
  logic [BIT_W-1:0]   bit_r;
  logic [MOL_W-1:0]   mol_r;
  logic               last_r;
  logic [31:0]        tab_q;
  logic [TAB_AW-1:0]  tix;

  function automatic logic [DIFF_W-1:0] absd(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : d;
  endfunction

  function automatic logic [TYP_AW-1:0] tred(input logic [TYPE_W-1:0] t);
    return TYP_AW'(32'(t) % ATOM_TYPES);
  endfunction

  assign tix = TAB_AW'(32'(tred(vapor_atom_type)) * ATOM_TYPES + 32'(tred(ion_atom_type)));
  assign in_ready = (state_r == S_IDLE);

  vch_ram #(.WIDTH(32), .DEPTH(TAB_D)) u_tab (
    .clk(clk), .we(in_valid && in_ready && action == ACT_LOAD), .waddr(tix),
    .wdata(table_value), .re(in_valid && in_ready && action == ACT_PAIR),
    .raddr(tix), .rdata(tab_q)
  );

  // Square root, one result bit a cycle: trial (2*root+bit)*bit against rem
  logic [DIST_W-1:0] trial_bit;
  logic [SQ_W-1:0]   trial_sub;
  assign trial_bit = DIST_W'(1) << bit_r;
  assign trial_sub = ((SQ_W'(root_r) << 1) + SQ_W'(trial_bit)) << bit_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && action == ACT_PAIR) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ROOT;
      S_ROOT: if (bit_r == '0) state_nxt = S_OUT;
      S_OUT:  if (!q_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    unique case (state_r)
      S_IDLE: begin
        dx_r   <= absd(vapor_x, ion_x);
        dy_r   <= absd(vapor_y, ion_y);
        dz_r   <= absd(vapor_z, ion_z);
        mol_r  <= MOL_W'(32'(VMW'(32'(vapor_index) % MAX_VAPORS)));
        last_r <= last_pair;
      end
      S_SQ: begin
        sqx_r <= 66'(dx_r) * 66'(dx_r);
        sqy_r <= 66'(dy_r) * 66'(dy_r);
        sqz_r <= 66'(dz_r) * 66'(dz_r);
      end
      S_SUM: begin
        rem_r  <= SQ_W'(sqx_r) + SQ_W'(sqy_r) + SQ_W'(sqz_r);
        root_r <= '0;
        bit_r  <= BIT_W'(32);
      end
      S_ROOT: begin
        if (trial_sub <= rem_r) begin
          rem_r  <= rem_r - trial_sub;
          root_r <= root_r | trial_bit;
        end
        if (bit_r != '0) bit_r <= bit_r - BIT_W'(1);
      end
      S_OUT: ;
      default: ;
    endcase
  end

  assign q_push      = (state_r == S_OUT) && !q_full;
  assign q_data.last = last_r;
  assign q_data.mol  = mol_r;
  assign q_data.gap  = $signed(GAP_W'(root_r)) - $signed(GAP_W'(tab_q));
endmodule

>>> sv/vch_fifo.sv
module vch_fifo
  import vch_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gap_item_t wdata,
  output logic      full,
  input  logic      pop,
  output gap_item_t rdata,
  output logic      empty
);
  gap_item_t  mem_r [2];
  logic [1:0] wp_r, rp_r;

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[0] == rp_r[0]) && (wp_r[1] != rp_r[1]);
  assign rdata = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
    end
    if (push) mem_r[wp_r[0]] <= wdata;
  end
endmodule

>>> sv/vch_back.sv
// Running minimum, flag store and hysteresis events.
// Flag store is a RAM cleared by one pass over all entries after reset.
module vch_back
  import vch_pkg::*;
#(
  parameter int MAX_VAPORS = MAX_VAPORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               q_empty,
  input  gap_item_t          q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MOL_W-1:0]   out_molecule,
  output logic               out_event_kind,
  output logic signed [31:0] out_min_gap,
  output logic               out_last_event
);
  localparam int VMW = (MAX_VAPORS > 1) ? $clog2(MAX_VAPORS) : 1;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_DEC   = 4'b0100,
    B_EMIT  = 4'b1000
  } bst_t;

  bst_t state_r;
  logic signed [31:0]      arrive_r, leave_r;
  logic signed [GAP_W-1:0] min_r;
  logic [VMW-1:0]          clr_r;
  gap_item_t               it_r;
  logic                    ov_r, kind_r, lastev_r;
  logic [MOL_W-1:0]        mol_r;
  logic signed [31:0]      gsat_r;

  logic signed [GAP_W-1:0] mn;
  logic [VMW-1:0]          fidx, ridx, f_waddr;
  logic                    lv, ar, fl;
  logic                    f_we, f_wdata;
  logic                    dec_fire, emit_go, ev_load;

  assign mn   = (it_r.gap < min_r) ? it_r.gap : min_r;
  assign fidx = VMW'(it_r.mol);
  assign ridx = VMW'(q_data.mol);
  assign lv   = (mn > GAP_W'(leave_r)) && fl;
  assign ar   = (mn < GAP_W'(arrive_r)) && (lv || !fl);
  assign q_pop = !q_empty && state_r == B_IDLE;

  // decision on a last pair waits for a free result register
  assign dec_fire = (state_r == B_DEC) && it_r.last && (!ov_r || !out_stall);
  assign emit_go  = (state_r == B_EMIT) && !out_stall;
  assign ev_load  = (dec_fire && (lv || ar)) || emit_go;

  assign f_we    = (state_r == B_CLEAR) || (dec_fire && (lv || ar));
  assign f_waddr = (state_r == B_CLEAR) ? clr_r : fidx;
  assign f_wdata = (state_r == B_CLEAR) ? 1'b0 : ar;

  vch_ram #(.WIDTH(1), .DEPTH(MAX_VAPORS)) u_flags (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(q_pop), .raddr(ridx), .rdata(fl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLEAR;
      clr_r    <= '0;
      arrive_r <= '0;
      leave_r  <= '0;
      min_r    <= MIN_START;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ARRIVE: arrive_r <= cfg_data;
          CFG_LEAVE:  leave_r  <= cfg_data;
          default: ;
        endcase
      end
      if (ev_load) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        B_CLEAR: begin
          if (clr_r == VMW'(MAX_VAPORS - 1)) state_r <= B_IDLE;
          else clr_r <= clr_r + VMW'(1);
        end
        B_IDLE: if (q_pop) begin
          it_r    <= q_data;
          state_r <= B_DEC;
        end
        B_DEC: begin
          if (!it_r.last) begin
            min_r   <= mn;
            state_r <= B_IDLE;
          end else if (dec_fire) begin
            min_r    <= MIN_START;
            mol_r    <= it_r.mol;
            gsat_r   <= sat32(mn);
            kind_r   <= lv ? EV_LEAVE : EV_ARRIVE;
            lastev_r <= !(lv && ar);
            state_r  <= (lv && ar) ? B_EMIT : B_IDLE;
          end
        end
        B_EMIT: if (emit_go) begin
          kind_r   <= EV_ARRIVE;
          lastev_r <= 1'b1;
          state_r  <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_molecule   = mol_r;
  assign out_event_kind = kind_r;
  assign out_min_gap    = gsat_r;
  assign out_last_event = lastev_r;
endmodule

>>> sv/vapor_contact_hysteresis.sv
// Pair item: diff, square, sum, 33-step square root, queue push in the front end,
// then pop and flag read, decision. A pair blocks the front end until pushed, so
// the bit-serial root sets the pair rate; load items are taken at once while idle.
// A second event follows once the first is taken. 2-deep queue between halves.
// Reset (rst_n low, synchronous): thresholds 0, running minimum restarted, then a
// pass clears all MAX_VAPORS (1024) flags to free; contact table not cleared.
module vapor_contact_hysteresis
  import vch_pkg::*;
#(
  parameter int MAX_VAPORS = MAX_VAPORS_DEF,
  parameter int ATOM_TYPES = ATOM_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [MOL_W-1:0]   in_vapor_index,
  input  logic [TYPE_W-1:0]  in_vapor_atom_type,
  input  logic [TYPE_W-1:0]  in_ion_atom_type,
  input  logic signed [31:0] in_vapor_x,
  input  logic signed [31:0] in_vapor_y,
  input  logic signed [31:0] in_vapor_z,
  input  logic signed [31:0] in_ion_x,
  input  logic signed [31:0] in_ion_y,
  input  logic signed [31:0] in_ion_z,
  input  logic               in_last_pair,
  input  logic [31:0]        in_table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MOL_W-1:0]   out_molecule,
  output logic               out_event_kind,
  output logic signed [31:0] out_min_gap,
  output logic               out_last_event
);
  logic      rdy, push, full, pop, empty;
  gap_item_t wq, rq;

  assign in_stall = !rdy;

  // front end: distance and gap per transaction
  vch_front #(.MAX_VAPORS(MAX_VAPORS), .ATOM_TYPES(ATOM_TYPES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(rdy),
    .action(in_action), .vapor_index(in_vapor_index),
    .vapor_atom_type(in_vapor_atom_type), .ion_atom_type(in_ion_atom_type),
    .vapor_x(in_vapor_x), .vapor_y(in_vapor_y), .vapor_z(in_vapor_z),
    .ion_x(in_ion_x), .ion_y(in_ion_y), .ion_z(in_ion_z),
    .last_pair(in_last_pair), .table_value(in_table_value),
    .q_push(push), .q_data(wq), .q_full(full)
  );

  vch_fifo u_q (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(wq), .full(full),
    .pop(pop), .rdata(rq), .empty(empty)
  );

  // back end: minimum fold and hysteresis
  vch_back #(.MAX_VAPORS(MAX_VAPORS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_empty(empty), .q_data(rq), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_molecule(out_molecule),
    .out_event_kind(out_event_kind), .out_min_gap(out_min_gap),
    .out_last_event(out_last_event)
  );
endmodule

>>> sv/vch_checker.sv
module vch_checker
  import vch_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_event_kind,
  input logic             out_last_event,
  input logic [MOL_W-1:0] out_molecule
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_molecule))
    else $error("stalled result changed");
  a_leave_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_event |-> out_event_kind == EV_LEAVE)
    else $error("non-final event not a leave");
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_event |=>
      out_valid && out_event_kind == EV_ARRIVE && $stable(out_molecule))
    else $error("arrive does not follow leave");
endmodule

bind vapor_contact_hysteresis vch_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_event_kind(out_event_kind), .out_last_event(out_last_event),
  .out_molecule(out_molecule)
);

>>> bench/vapor_contact_hysteresis_tb.sv
module vapor_contact_hysteresis_tb;
  import vch_pkg::*;

  // One input transaction, one field per port
  typedef struct {
    logic        act;
    logic [9:0]  vi;
    logic [3:0]  vt;
    logic [3:0]  it;
    logic [31:0] vx, vy, vz, ix, iy, iz;
    logic        last;
    logic [31:0] tv;
  } sample_t;

  // One binding event as seen on the result channel
  typedef struct {
    logic [9:0]  mol;
    logic        kind;
    logic [31:0] gap;
    logic        last;
  } bind_ev_t;

  // Directed row: n_typed < 0 means the predictor supplies the events,
  // otherwise the row holds its own (zero or one event).
  typedef struct {
    sample_t     s;
    int          n_typed;
    logic        kind;
    logic [31:0] gap;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic in_action, in_last_pair;
  logic [MOL_W-1:0] in_vapor_index;
  logic [TYPE_W-1:0] in_vapor_atom_type, in_ion_atom_type;
  logic signed [31:0] in_vapor_x, in_vapor_y, in_vapor_z, in_ion_x, in_ion_y, in_ion_z;
  logic [31:0] in_table_value;
  logic out_valid, out_stall;
  logic [MOL_W-1:0] out_molecule;
  logic out_event_kind, out_last_event;
  logic signed [31:0] out_min_gap;

  vapor_contact_hysteresis u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state: own copy of table, flags, running minimum, thresholds
  logic [31:0]        contact_mem [256];
  bit                 contact_loaded [256];
  bit                 bound_mem [1024];
  logic signed [34:0] gap_floor;
  logic signed [31:0] arrive_thr, leave_thr;

  bind_ev_t pending_events[$];
  int  mismatches = 0;
  int  n_trans = 0, n_leave = 0, n_arrive = 0, n_both = 0;
  bit  quiet = 1'b0;

  function automatic logic [32:0] mag_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = 33'($signed(a)) - 33'($signed(b));
    return (d < 0) ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [33:0] floor_root(logic [67:0] s);
    logic [33:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (68'(c) * 68'(c) <= s) r = c;
    end
    return r;
  endfunction

  // Folds one accepted transaction into the predictor; returns the events it causes
  function automatic int predict_binding(sample_t s, output bind_ev_t evs[2]);
    logic [7:0]         tix;
    logic [32:0]        dx, dy, dz;
    logic [67:0]        sum;
    logic signed [34:0] gap, mn, tl, ta;
    logic [31:0]        gsat;
    logic [9:0]         mol;
    int                 n;
    n = 0;
    tix = {s.vt, s.it};
    if (s.act == ACT_LOAD) begin
      contact_mem[tix] = s.tv;
      contact_loaded[tix] = 1'b1;
      return 0;
    end
    dx = mag_diff(s.vx, s.ix);
    dy = mag_diff(s.vy, s.iy);
    dz = mag_diff(s.vz, s.iz);
    sum = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    gap = $signed(35'(floor_root(sum))) - $signed(35'(contact_mem[tix]));
    if (gap < gap_floor) gap_floor = gap;
    if (!s.last) return 0;
    mn = gap_floor;
    gap_floor = MIN_START;
    mol = s.vi;
    tl = leave_thr;
    ta = arrive_thr;
    if (mn > 35'sd2147483647) gsat = 32'h7fffffff;
    else if (mn < -35'sd2147483648) gsat = 32'h80000000;
    else gsat = mn[31:0];
    if (mn > tl && bound_mem[mol]) begin
      bound_mem[mol] = 1'b0;
      evs[n] = '{mol, EV_LEAVE, gsat, 1'b0};
      n++;
    end
    if (mn < ta && !bound_mem[mol]) begin
      bound_mem[mol] = 1'b1;
      evs[n] = '{mol, EV_ARRIVE, gsat, 1'b0};
      n++;
    end
    if (n > 0) evs[n-1].last = 1'b1;
    return n;
  endfunction

  // Drives one transaction, with an optional idle burst ahead of it, and
  // holds it until accepted. Valid is left high for a back-to-back follower.
  task automatic send(row_t r);
    bind_ev_t evs[2];
    int       n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= r.s.act;
    in_vapor_index     <= r.s.vi;
    in_vapor_atom_type <= r.s.vt;
    in_ion_atom_type   <= r.s.it;
    in_vapor_x <= r.s.vx; in_vapor_y <= r.s.vy; in_vapor_z <= r.s.vz;
    in_ion_x   <= r.s.ix; in_ion_y   <= r.s.iy; in_ion_z   <= r.s.iz;
    in_last_pair       <= r.s.last;
    in_table_value     <= r.s.tv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_trans++;
    n = predict_binding(r.s, evs);
    if (n == 2) n_both++;
    if (r.n_typed >= 0) begin
      // typed rows replace the prediction; predictor still tracks state
      if (r.n_typed == 1) pending_events.push_back('{r.s.vi, r.kind, r.gap, 1'b1});
    end else begin
      for (int k = 0; k < n; k++) pending_events.push_back(evs[k]);
    end
  endtask

  // Waits for the block to go quiet: all events back, plus the front-end depth
  // since pairs without a last flag produce nothing to wait on.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [31:0] a, logic [31:0] l);
    cfg_we <= 1'b1; cfg_index <= CFG_ARRIVE; cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_LEAVE; cfg_data <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    arrive_thr = a;
    leave_thr  = l;
  endtask

  function automatic row_t mk(logic act, logic [9:0] vi, logic [3:0] vt, logic [3:0] it,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                              logic last, logic [31:0] tv,
                              int nt, logic kind, logic [31:0] gap);
    row_t r;
    r.s = '{act, vi, vt, it, vx, vy, vz, ix, iy, iz, last, tv};
    r.n_typed = nt; r.kind = kind; r.gap = gap;
    return r;
  endfunction

  // Random pair against a loaded table entry; mostly ion close to vapor so that
  // gaps fall around the thresholds, sometimes full-range coordinates.
  function automatic row_t rand_pair(logic [9:0] mol, logic last);
    row_t        r;
    int unsigned t;
    logic [31:0] v[3], o[3];
    do t = $urandom_range(0, 255); while (!contact_loaded[t]);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        v[k] = $urandom; o[k] = $urandom;
      end else begin
        v[k] = $urandom_range(0, 32'h3fffff) - 32'h200000;
        o[k] = v[k] + $urandom_range(0, 32'hfffff) - 32'h80000;
      end
    end
    r = mk(ACT_PAIR, mol, t[7:4], t[3:0], v[0], v[1], v[2], o[0], o[1], o[2],
           last, $urandom, -1, EV_LEAVE, '0);
    return r;
  endfunction

  function automatic row_t rand_load();
    logic [31:0] tv;
    tv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'hc0000);
    return mk(ACT_LOAD, 10'($urandom), 4'($urandom), 4'($urandom), $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, 1'($urandom), tv, 0, EV_LEAVE, '0);
  endfunction

  // Result side: compare every accepted event with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: mol %0d kind %0d gap %h last %0d", out_molecule,
                   out_event_kind, out_min_gap, out_last_event);
      end else begin
        bind_ev_t e;
        e = pending_events.pop_front();
        if (out_molecule !== e.mol || out_event_kind !== e.kind ||
            out_min_gap !== e.gap || out_last_event !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: exp mol %0d kind %0d gap %h last %0d, got %0d %0d %h %0d",
                     e.mol, e.kind, e.gap, e.last, out_molecule, out_event_kind,
                     out_min_gap, out_last_event);
        end
        if (e.kind == EV_LEAVE) n_leave++; else n_arrive++;
      end
    end
  end

  // Receiver: random stall bursts, none once quiet
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t        dir[$];
    row_t        r;
    logic [31:0] thr_a[5], thr_l[5];
    logic [9:0]  mol;
    int          npairs;

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_action = 1'b0; in_vapor_index = '0;
    in_vapor_atom_type = '0; in_ion_atom_type = '0;
    in_vapor_x = '0; in_vapor_y = '0; in_vapor_z = '0;
    in_ion_x = '0; in_ion_y = '0; in_ion_z = '0;
    in_last_pair = 1'b0; in_table_value = '0;
    foreach (bound_mem[i]) bound_mem[i] = 1'b0;
    foreach (contact_loaded[i]) contact_loaded[i] = 1'b0;
    foreach (contact_mem[i]) contact_mem[i] = '0;
    gap_floor = MIN_START;
    arrive_thr = '0;
    leave_thr = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, thresholds at their reset value of zero
    dir.push_back(mk(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0, EV_LEAVE, '0));
    dir.push_back(mk(ACT_LOAD, 0, 15, 15, 0, 0, 0, 0, 0, 0, 1, 32'hffffffff,
                     0, EV_LEAVE, '0));
    dir.push_back(mk(ACT_LOAD, 1023, 3, 5, 0, 0, 0, 0, 0, 0, 0, 32'h10000,
                     0, EV_LEAVE, '0));
    // distance 5.0, gap positive: free molecule stays free
    dir.push_back(mk(ACT_PAIR, 7, 0, 0, 32'h30000, 32'h40000, 0, 0, 0, 0, 1, 0,
                     0, EV_LEAVE, '0));
    // huge contact distance: gap saturates low, molecule arrives
    dir.push_back(mk(ACT_PAIR, 1023, 15, 15, 32'h30000, 32'h40000, 0, 0, 0, 0, 1, 0,
                     1, EV_ARRIVE, 32'h80000000));
    // coordinates at opposite extremes: gap saturates high, molecule leaves
    dir.push_back(mk(ACT_PAIR, 1023, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000, 1, 0,
                     1, EV_LEAVE, 32'h7fffffff));
    // coincident atoms: gap is minus the contact distance
    dir.push_back(mk(ACT_PAIR, 2, 3, 5, 32'h12345, 32'hfff00000, 32'h1, 32'h12345,
                     32'hfff00000, 32'h1, 1, 0, 1, EV_ARRIVE, 32'hffff0000));
    dir.push_back(mk(ACT_PAIR, 2, 0, 0, 0, 0, 0, 32'hfffd0000, 32'hfffc0000, 0, 1, 0,
                     1, EV_LEAVE, 32'h50000));
    // mixed molecules folded into one minimum, decided on the last index
    dir.push_back(mk(ACT_PAIR, 3, 3, 5, 0, 0, 0, 32'h8000, 0, 0, 0, 0, -1, EV_LEAVE, '0));
    dir.push_back(mk(ACT_PAIR, 9, 0, 0, 32'h90000, 0, 0, 0, 0, 0, 0, 0, -1, EV_LEAVE, '0));
    // a load between pairs leaves the running minimum alone
    dir.push_back(mk(ACT_LOAD, 0, 3, 5, 0, 0, 0, 0, 0, 0, 1, 32'h20000, 0, EV_LEAVE, '0));
    dir.push_back(mk(ACT_PAIR, 9, 0, 0, 32'h90000, 0, 0, 0, 0, 0, 1, 0, -1, EV_LEAVE, '0));
    dir.push_back(mk(ACT_PAIR, 512, 3, 5, 32'h10000, 0, 0, 0, 0, 0, 1, 0,
                     -1, EV_LEAVE, '0));
    foreach (dir[i]) send(dir[i]);
    drain();

    // Random part in phases of differing thresholds; the last phase runs
    // without idling on either side.
    thr_a = '{32'h20000, 32'ha0000, 32'h7fffffff, 32'h80000000, 32'h30000};
    thr_l = '{32'h50000, 32'hfffd0000, 32'h80000000, 32'h7fffffff, 32'h40000};
    for (int p = 0; p < 5; p++) begin
      set_thresholds(thr_a[p], thr_l[p]);
      if (p == 4) quiet = 1'b1;
      for (int q = 0; q < 140; ) begin
        if ($urandom_range(0, 9) == 0) begin
          send(rand_load());
          q++;
        end else begin
          mol = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
          npairs = $urandom_range(1, 4);
          for (int k = 0; k < npairs; k++) begin
            r = rand_pair(mol, k == npairs - 1);
            // noise: stray indices and stray last flags
            if ($urandom_range(0, 11) == 0) r.s.vi = 10'($urandom);
            if ($urandom_range(0, 11) == 0) r.s.last = 1'($urandom);
            send(r);
            q++;
          end
        end
      end
      drain();
    end

    if (pending_events.size() != 0) mismatches++;
    $display("covered %0d transactions, %0d leave and %0d arrive events (%0d double)",
             n_trans, n_leave, n_arrive, n_both);
    $display("five threshold phases incl. both extremes, idle bursts on both sides");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
